// ----- src/bsc_pkg.sv -----
// shared types, constants and helper functions of the boid steering combiner
`default_nettype none

package bsc_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int ANGLE_ITERS = 16;
  localparam int SQRT_ITERS  = 32;
  // quotient bits of a speed rescale: the quotient never exceeds the 24-bit limit
  localparam int DIV_QBITS   = 25;
  localparam int CNT_W       = 5;
  localparam int ACC_W       = 36;
  localparam int ANG_W       = 21;
  localparam int CORD_W      = 36;

  localparam logic [63:0] PI_Q30    = 64'd3373259426;
  localparam logic [63:0] ROUND_Q30 = 64'd1 << (29 - FRAC_BITS);
  localparam logic signed [ANG_W-1:0] PI_Q =
    ANG_W'((PI_Q30 + ROUND_Q30) >> (30 - FRAC_BITS));

  // reciprocal of 25 scaled by 2^32, rounded up
  localparam logic [63:0] JIT_RECIP = ((64'd1 << 32) + 64'd24) / 64'd25;

  // register indexes
  localparam logic [2:0] CFG_COHESION_GAIN  = 3'd0;
  localparam logic [2:0] CFG_ALIGNMENT_GAIN = 3'd1;
  localparam logic [2:0] CFG_MIN_SPEED      = 3'd2;
  localparam logic [2:0] CFG_MAX_SPEED      = 3'd3;
  localparam logic [2:0] CFG_BOUND_PUSH     = 3'd4;
  localparam logic [2:0] CFG_HALF_WIDTH_X   = 3'd5;
  localparam logic [2:0] CFG_HALF_WIDTH_Z   = 3'd6;
  localparam logic [2:0] CFG_ROTATE_SMOOTH  = 3'd7;

  // push direction codes
  localparam logic [1:0] PUSH_NONE  = 2'd0;
  localparam logic [1:0] PUSH_PLUS  = 2'd1;
  localparam logic [1:0] PUSH_MINUS = 2'd2;

  // jitter event codes
  localparam logic [1:0] JIT_KEEP   = 2'd0;
  localparam logic [1:0] JIT_NARROW = 2'd1;
  localparam logic [1:0] JIT_WIDE   = 2'd2;

  typedef struct packed {
    logic [16:0] cohesion_gain;
    logic [16:0] alignment_gain;
    logic [23:0] min_speed;
    logic [23:0] max_speed;
    logic [23:0] bound_push;
    logic [30:0] half_width_x;
    logic [30:0] half_width_z;
    logic        rotate_smooth;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] sep_x;
    logic signed [31:0] sep_z;
    logic signed [31:0] coh_x;
    logic signed [31:0] coh_z;
    logic signed [31:0] ali_x;
    logic signed [31:0] ali_z;
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_z;
    logic [16:0]        time_step;
    logic [1:0]         jitter_event;
    logic [5:0]         jitter_draw_x;
    logic [5:0]         jitter_draw_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_z;
    logic signed [18:0] heading;
  } out_item_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_JITTER, OP_INIT,
    OP_MUL_CX, OP_MUL_CZ, OP_MUL_AX, OP_MUL_AZ, OP_ACC_X, OP_ACC_Z,
    OP_SAT, OP_SQ_X, OP_SQ_Z, OP_SQ_SUM, OP_SQRT, OP_LIMIT,
    OP_MUL_VX, OP_MUL_VZ, OP_DIV_INIT, OP_DIV, OP_DIV_END_X, OP_DIV_END_Z,
    OP_CORDIC_INIT, OP_CORDIC, OP_EASE_MUL, OP_EASE_ADD, OP_PUBLISH
  } dp_op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_JITTER, S_INIT,
    S_MUL_CX, S_ACC_CX, S_MUL_CZ, S_ACC_CZ,
    S_MUL_AX, S_ACC_AX, S_MUL_AZ, S_ACC_AZ,
    S_SAT, S_SQ_X, S_SQ_Z, S_SQ_SUM, S_SQRT, S_LIMIT,
    S_MUL_VX, S_DIV_INIT_X, S_DIV_X, S_DIV_END_X,
    S_MUL_VZ, S_DIV_INIT_Z, S_DIV_Z, S_DIV_END_Z,
    S_CORDIC_INIT, S_CORDIC, S_EASE_MUL, S_EASE_ADD, S_DONE
  } state_t;

  typedef struct packed {
    dp_op_t           op;
    logic             load;
    logic [CNT_W-1:0] iter;
  } dp_cmd_t;

  typedef struct packed {
    logic clamp;
  } dp_stat_t;

  // arctangent of 2^-i in radians, Q30
  function automatic logic [63:0] atan_q30(input logic [CNT_W-1:0] i);
    logic [63:0] v;
    case (i)
      5'd0:  v = 64'd843314857;
      5'd1:  v = 64'd497837829;
      5'd2:  v = 64'd263043837;
      5'd3:  v = 64'd133525159;
      5'd4:  v = 64'd67021687;
      5'd5:  v = 64'd33543516;
      5'd6:  v = 64'd16775851;
      5'd7:  v = 64'd8388437;
      5'd8:  v = 64'd4194283;
      5'd9:  v = 64'd2097149;
      5'd10: v = 64'd1048576;
      5'd11: v = 64'd524288;
      5'd12: v = 64'd262144;
      5'd13: v = 64'd131072;
      5'd14: v = 64'd65536;
      5'd15: v = 64'd32768;
      5'd16: v = 64'd16384;
      5'd17: v = 64'd8192;
      5'd18: v = 64'd4096;
      5'd19: v = 64'd2048;
      5'd20: v = 64'd1024;
      5'd21: v = 64'd512;
      5'd22: v = 64'd256;
      5'd23: v = 64'd128;
      default: v = 64'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [ANG_W-1:0] atan_q(input logic [CNT_W-1:0] i);
    return ANG_W'((atan_q30(i) + ROUND_Q30) >> (30 - FRAC_BITS));
  endfunction

  // (2r - m) * 2^F / 200 rounded half away from zero, r = draw mod m
  function automatic logic signed [31:0] jitter_value(input logic [5:0] draw,
                                                      input logic wide);
    logic [6:0]        m;
    logic [6:0]        r;
    logic signed [8:0] d;
    logic [5:0]        mag;
    logic [63:0]       x;
    logic [63:0]       q;
    m = wide ? 7'd40 : 7'd30;
    r = {1'b0, draw};
    if (r >= m) r = r - m;
    if (r >= m) r = r - m;
    d = $signed({1'b0, r, 1'b0}) - $signed({2'b00, m});
    mag = d[8] ? 6'(-d) : 6'(d);
    x = (64'(mag) << (FRAC_BITS - 3)) + 64'd12;
    q = (x * JIT_RECIP) >> 32;
    return d[8] ? -32'(q) : 32'(q);
  endfunction

endpackage

`default_nettype wire

// ----- src/boid_steering_combiner.sv -----
// boid steering combiner: velocity sum, speed clamp and heading per boid
// one item at a time: a new input is accepted only in the idle state, after the 32-step
//   square root, the two 25-step rescale divisions (only when the speed is rescaled) and
//   the 16-step cordic of the last item have run on one shared datapath
// a finished result waits in the output register while the next item is taken
// reset: rst_n synchronous active low; clears heading, jitter and push state and loads
//   the register defaults
`default_nettype none

module boid_steering_combiner (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // sep_x, sep_z, coh_x, coh_z, ali_x, ali_z, offset_x, offset_z, time_step,
  // jitter_event, jitter_draw_x, jitter_draw_z, zero pad
  input  wire logic [287:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // vel_x, vel_z, heading, zero pad
  output logic [87:0]       out_tdata,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [30:0]  cfg_wdata
);
  import bsc_pkg::*;

  cfg_t      cfg;
  in_item_t  in_item;
  out_item_t out_item;
  dp_cmd_t   cmd;
  dp_stat_t  stat;

  assign in_item.sep_x         = in_tdata[31:0];
  assign in_item.sep_z         = in_tdata[63:32];
  assign in_item.coh_x         = in_tdata[95:64];
  assign in_item.coh_z         = in_tdata[127:96];
  assign in_item.ali_x         = in_tdata[159:128];
  assign in_item.ali_z         = in_tdata[191:160];
  assign in_item.offset_x      = in_tdata[223:192];
  assign in_item.offset_z      = in_tdata[255:224];
  assign in_item.time_step     = in_tdata[272:256];
  assign in_item.jitter_event  = in_tdata[274:273];
  assign in_item.jitter_draw_x = in_tdata[280:275];
  assign in_item.jitter_draw_z = in_tdata[286:281];

  assign out_tdata = {5'b0, out_item.heading, out_item.vel_z, out_item.vel_x};

  bsc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bsc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  bsc_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .cfg      (cfg),
    .stat     (stat),
    .out_item (out_item)
  );

endmodule

`default_nettype wire

// ----- src/bsc_cfg.sv -----
// configuration register bank of the boid steering combiner
`default_nettype none

module bsc_cfg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_we,
  input  wire logic [2:0]    cfg_index,
  input  wire logic [30:0]   cfg_wdata,
  output bsc_pkg::cfg_t      cfg
);
  import bsc_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cohesion_gain  <= 17'd459;
      cfg_r.alignment_gain <= 17'd58982;
      cfg_r.min_speed      <= 24'd983040;
      cfg_r.max_speed      <= 24'd1966080;
      cfg_r.bound_push     <= 24'd655360;
      cfg_r.half_width_x   <= 31'd13107200;
      cfg_r.half_width_z   <= 31'd13107200;
      cfg_r.rotate_smooth  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COHESION_GAIN:  cfg_r.cohesion_gain  <= cfg_wdata[16:0];
        CFG_ALIGNMENT_GAIN: cfg_r.alignment_gain <= cfg_wdata[16:0];
        CFG_MIN_SPEED:      cfg_r.min_speed      <= cfg_wdata[23:0];
        CFG_MAX_SPEED:      cfg_r.max_speed      <= cfg_wdata[23:0];
        CFG_BOUND_PUSH:     cfg_r.bound_push     <= cfg_wdata[23:0];
        CFG_HALF_WIDTH_X:   cfg_r.half_width_x   <= cfg_wdata[30:0];
        CFG_HALF_WIDTH_Z:   cfg_r.half_width_z   <= cfg_wdata[30:0];
        CFG_ROTATE_SMOOTH:  cfg_r.rotate_smooth  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ----- src/bsc_ctrl.sv -----
// sequencer of the boid steering combiner
`default_nettype none

module bsc_ctrl (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire bsc_pkg::dp_stat_t stat,
  output bsc_pkg::dp_cmd_t  cmd
);
  import bsc_pkg::*;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_tready;
    in_tready     = 1'b0;
    cmd           = '{op: OP_NONE, load: 1'b0, iter: cnt_r};
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_JITTER;
        end
      end
      S_JITTER:   begin cmd.op = OP_JITTER; state_nxt = S_INIT;   end
      S_INIT:     begin cmd.op = OP_INIT;   state_nxt = S_MUL_CX; end
      S_MUL_CX:   begin cmd.op = OP_MUL_CX; state_nxt = S_ACC_CX; end
      S_ACC_CX:   begin cmd.op = OP_ACC_X;  state_nxt = S_MUL_CZ; end
      S_MUL_CZ:   begin cmd.op = OP_MUL_CZ; state_nxt = S_ACC_CZ; end
      S_ACC_CZ:   begin cmd.op = OP_ACC_Z;  state_nxt = S_MUL_AX; end
      S_MUL_AX:   begin cmd.op = OP_MUL_AX; state_nxt = S_ACC_AX; end
      S_ACC_AX:   begin cmd.op = OP_ACC_X;  state_nxt = S_MUL_AZ; end
      S_MUL_AZ:   begin cmd.op = OP_MUL_AZ; state_nxt = S_ACC_AZ; end
      S_ACC_AZ:   begin cmd.op = OP_ACC_Z;  state_nxt = S_SAT;    end
      S_SAT:      begin cmd.op = OP_SAT;    state_nxt = S_SQ_X;   end
      S_SQ_X:     begin cmd.op = OP_SQ_X;   state_nxt = S_SQ_Z;   end
      S_SQ_Z:     begin cmd.op = OP_SQ_Z;   state_nxt = S_SQ_SUM; end
      S_SQ_SUM:   begin cmd.op = OP_SQ_SUM; state_nxt = S_SQRT;   end
      S_SQRT: begin
        cmd.op = OP_SQRT;
        if (cnt_r == CNT_W'(SQRT_ITERS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_LIMIT;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_LIMIT: begin
        cmd.op    = OP_LIMIT;
        state_nxt = stat.clamp ? S_MUL_VX : S_CORDIC_INIT;
      end
      S_MUL_VX:     begin cmd.op = OP_MUL_VX;   state_nxt = S_DIV_INIT_X; end
      S_DIV_INIT_X: begin cmd.op = OP_DIV_INIT; state_nxt = S_DIV_X;      end
      S_DIV_X: begin
        cmd.op = OP_DIV;
        if (cnt_r == CNT_W'(DIV_QBITS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_DIV_END_X;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DIV_END_X:  begin cmd.op = OP_DIV_END_X; state_nxt = S_MUL_VZ;     end
      S_MUL_VZ:     begin cmd.op = OP_MUL_VZ;    state_nxt = S_DIV_INIT_Z; end
      S_DIV_INIT_Z: begin cmd.op = OP_DIV_INIT;  state_nxt = S_DIV_Z;      end
      S_DIV_Z: begin
        cmd.op = OP_DIV;
        if (cnt_r == CNT_W'(DIV_QBITS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_DIV_END_Z;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DIV_END_Z:   begin cmd.op = OP_DIV_END_Z;   state_nxt = S_CORDIC_INIT; end
      S_CORDIC_INIT: begin cmd.op = OP_CORDIC_INIT; state_nxt = S_CORDIC;      end
      S_CORDIC: begin
        cmd.op = OP_CORDIC;
        if (cnt_r == CNT_W'(ANGLE_ITERS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_EASE_MUL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_EASE_MUL: begin cmd.op = OP_EASE_MUL; state_nxt = S_EASE_ADD; end
      S_EASE_ADD: begin cmd.op = OP_EASE_ADD; state_nxt = S_DONE;     end
      S_DONE: begin
        // wait for the output register to be free
        if (!out_valid_r || out_tready) begin
          cmd.op        = OP_PUBLISH;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

// ----- src/bsc_dp.sv -----
// datapath of the boid steering combiner: shared multiplier, sqrt, divider, cordic
`default_nettype none

module bsc_dp (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire bsc_pkg::dp_cmd_t  cmd,
  input  wire bsc_pkg::in_item_t in_item,
  input  wire bsc_pkg::cfg_t     cfg,
  output bsc_pkg::dp_stat_t  stat,
  output bsc_pkg::out_item_t out_item
);
  import bsc_pkg::*;

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sd2147483647);
  localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(64'sd2147483648);

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  // state kept from item to item
  logic signed [31:0] jit_x_r, jit_z_r;
  logic [1:0]         push_x_r, push_z_r;
  logic signed [18:0] heading_now_r;

  // working registers
  in_item_t                 it_r;
  logic signed [ACC_W-1:0]  acc_x_r, acc_z_r;
  logic signed [31:0]       vx_r, vz_r;
  logic [63:0]              prod_r;
  logic                     neg_r;
  logic [63:0]              rad_r;
  logic [32:0]              srem_r;
  logic [31:0]              root_r;
  logic [23:0]              lim_r;
  logic [31:0]              drem_r;
  logic [DIV_QBITS-1:0]     quo_r;
  logic signed [CORD_W-1:0] cx_r, cy_r;
  logic signed [ANG_W-1:0]  ang_r;
  logic                     zero_r, zneg_r;
  logic signed [18:0]       head_r;
  out_item_t                out_r;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic        mul_neg, mul_en;

  logic signed [ANG_W-1:0] ang_sat, target, diff;
  logic [ANG_W-1:0]        diff_mag;

  always_comb begin
    ang_sat = ang_r;
    if (ang_r > PI_Q) ang_sat = PI_Q;
    else if (ang_r < -PI_Q) ang_sat = -PI_Q;
    if (zero_r) target = zneg_r ? PI_Q : '0;
    else target = ang_sat;
    diff     = target - ANG_W'(heading_now_r);
    diff_mag = diff[ANG_W-1] ? ANG_W'(-diff) : ANG_W'(diff);
  end

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    mul_en  = 1'b1;
    case (cmd.op)
      OP_MUL_CX: begin
        mul_a = mag32(it_r.coh_x); mul_b = 32'(cfg.cohesion_gain); mul_neg = it_r.coh_x[31];
      end
      OP_MUL_CZ: begin
        mul_a = mag32(it_r.coh_z); mul_b = 32'(cfg.cohesion_gain); mul_neg = it_r.coh_z[31];
      end
      OP_MUL_AX: begin
        mul_a = mag32(it_r.ali_x); mul_b = 32'(cfg.alignment_gain); mul_neg = it_r.ali_x[31];
      end
      OP_MUL_AZ: begin
        mul_a = mag32(it_r.ali_z); mul_b = 32'(cfg.alignment_gain); mul_neg = it_r.ali_z[31];
      end
      OP_SQ_X: begin
        mul_a = mag32(vx_r); mul_b = mag32(vx_r);
      end
      OP_SQ_Z: begin
        mul_a = mag32(vz_r); mul_b = mag32(vz_r);
      end
      OP_MUL_VX: begin
        mul_a = mag32(vx_r); mul_b = 32'(lim_r); mul_neg = vx_r[31];
      end
      OP_MUL_VZ: begin
        mul_a = mag32(vz_r); mul_b = 32'(lim_r); mul_neg = vz_r[31];
      end
      OP_EASE_MUL: begin
        mul_a = 32'(diff_mag); mul_b = 32'({it_r.time_step, 1'b0}); mul_neg = diff[ANG_W-1];
      end
      default: mul_en = 1'b0;
    endcase
  end

  // product / 2^F rounded half away from zero
  logic [63:0]             rnd_mag;
  logic signed [ACC_W-1:0] rnd_s;
  assign rnd_mag = (prod_r + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
  assign rnd_s   = neg_r ? -$signed(ACC_W'(rnd_mag)) : $signed(ACC_W'(rnd_mag));

  function automatic logic signed [ACC_W-1:0] push_term(input logic [1:0] dir,
                                                        input logic [23:0] push);
    logic signed [ACC_W-1:0] p;
    p = $signed(ACC_W'(push));
    if (dir == PUSH_PLUS) return p;
    if (dir == PUSH_MINUS) return -p;
    return '0;
  endfunction

  function automatic logic [1:0] push_next(input logic [1:0] dir,
                                           input logic signed [31:0] off,
                                           input logic [30:0] half);
    logic signed [32:0] o, h;
    o = 33'(off);
    h = $signed({2'b00, half});
    if (o > h) return PUSH_MINUS;
    if (o < -h) return PUSH_PLUS;
    return dir;
  endfunction

  // sqrt step, two radicand bits per step
  logic [34:0] sq_rem2, sq_trial, sq_diff;
  logic        sq_ge;
  assign sq_rem2  = {srem_r, rad_r[63:62]};
  assign sq_trial = {1'b0, root_r, 2'b01};
  assign sq_diff  = sq_rem2 - sq_trial;
  assign sq_ge    = sq_rem2 >= sq_trial;

  // restoring division step, divisor is the length
  logic [32:0] dv_t, dv_diff;
  logic        dv_ge;
  logic [63:0] dv_num;
  assign dv_t    = {drem_r, rad_r[63]};
  assign dv_diff = dv_t - {1'b0, root_r};
  assign dv_ge   = dv_t >= {1'b0, root_r};
  assign dv_num  = prod_r + 64'(root_r >> 1);

  // speed limit selection
  logic        lim_hi, lim_lo;
  assign lim_hi     = root_r > 32'(cfg.max_speed);
  assign lim_lo     = root_r < 32'(cfg.min_speed);
  assign stat.clamp = (it_r.time_step != '0) && (root_r != '0) && (lim_hi || lim_lo);

  // cordic step
  logic signed [CORD_W-1:0] cx_sh, cy_sh;
  logic signed [ANG_W-1:0]  at;
  assign cx_sh = cx_r >>> cmd.iter;
  assign cy_sh = cy_r >>> cmd.iter;
  assign at    = atan_q(cmd.iter);

  logic signed [CORD_W-1:0] vx_e, vz_e;
  assign vx_e = CORD_W'(vx_r);
  assign vz_e = CORD_W'(vz_r);

  // eased heading
  logic signed [ACC_W-1:0] hs, hs_sat;
  always_comb begin
    hs     = ACC_W'(heading_now_r) + rnd_s;
    hs_sat = hs;
    if (hs > ACC_W'(PI_Q)) hs_sat = ACC_W'(PI_Q);
    else if (hs < -ACC_W'(PI_Q)) hs_sat = -ACC_W'(PI_Q);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jit_x_r       <= '0;
      jit_z_r       <= '0;
      push_x_r      <= PUSH_NONE;
      push_z_r      <= PUSH_NONE;
      heading_now_r <= '0;
    end else begin
      if (cmd.op == OP_JITTER) begin
        if (it_r.jitter_event == JIT_NARROW || it_r.jitter_event == JIT_WIDE) begin
          jit_x_r <= jitter_value(it_r.jitter_draw_x, it_r.jitter_event == JIT_WIDE);
          jit_z_r <= jitter_value(it_r.jitter_draw_z, it_r.jitter_event == JIT_WIDE);
        end
        push_x_r <= push_next(push_x_r, it_r.offset_x, cfg.half_width_x);
        push_z_r <= push_next(push_z_r, it_r.offset_z, cfg.half_width_z);
      end
      if (cmd.op == OP_PUBLISH) heading_now_r <= head_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) it_r <= in_item;
    if (mul_en) begin
      prod_r <= 64'(mul_a) * 64'(mul_b);
      neg_r  <= mul_neg;
    end
    case (cmd.op)
      OP_INIT: begin
        acc_x_r <= ACC_W'(it_r.sep_x) + ACC_W'(jit_x_r) + push_term(push_x_r, cfg.bound_push);
        acc_z_r <= ACC_W'(it_r.sep_z) + ACC_W'(jit_z_r) + push_term(push_z_r, cfg.bound_push);
      end
      OP_ACC_X: acc_x_r <= acc_x_r + rnd_s;
      OP_ACC_Z: acc_z_r <= acc_z_r + rnd_s;
      OP_SAT: begin
        vx_r <= (acc_x_r > SAT_HI) ? 32'(SAT_HI) : (acc_x_r < SAT_LO) ? 32'(SAT_LO)
                                                 : 32'(acc_x_r);
        vz_r <= (acc_z_r > SAT_HI) ? 32'(SAT_HI) : (acc_z_r < SAT_LO) ? 32'(SAT_LO)
                                                 : 32'(acc_z_r);
      end
      OP_SQ_Z: rad_r <= prod_r;
      OP_SQ_SUM: begin
        rad_r  <= rad_r + prod_r;
        srem_r <= '0;
        root_r <= '0;
      end
      OP_SQRT: begin
        srem_r <= sq_ge ? 33'(sq_diff) : 33'(sq_rem2);
        root_r <= {root_r[30:0], sq_ge};
        rad_r  <= rad_r << 2;
      end
      OP_LIMIT: lim_r <= lim_hi ? cfg.max_speed : cfg.min_speed;
      OP_DIV_INIT: begin
        drem_r <= 32'(dv_num >> DIV_QBITS);
        rad_r  <= dv_num << (64 - DIV_QBITS);
        quo_r  <= '0;
      end
      OP_DIV: begin
        drem_r <= dv_ge ? 32'(dv_diff) : 32'(dv_t);
        quo_r  <= {quo_r[DIV_QBITS-2:0], dv_ge};
        rad_r  <= rad_r << 1;
      end
      OP_DIV_END_X: vx_r <= neg_r ? -32'(quo_r) : 32'(quo_r);
      OP_DIV_END_Z: vz_r <= neg_r ? -32'(quo_r) : 32'(quo_r);
      OP_CORDIC_INIT: begin
        zero_r <= (vx_r == '0);
        zneg_r <= vz_r[31];
        // rotate the left half plane by pi first
        if (vz_r[31]) begin
          cx_r  <= -vz_e;
          cy_r  <= -vx_e;
          ang_r <= vx_r[31] ? -PI_Q : PI_Q;
        end else begin
          cx_r  <= vz_e;
          cy_r  <= vx_e;
          ang_r <= '0;
        end
      end
      OP_CORDIC: begin
        if (cy_r > 0) begin
          cx_r  <= cx_r + cy_sh;
          cy_r  <= cy_r - cx_sh;
          ang_r <= ang_r + at;
        end else begin
          cx_r  <= cx_r - cy_sh;
          cy_r  <= cy_r + cx_sh;
          ang_r <= ang_r - at;
        end
      end
      OP_EASE_ADD: head_r <= cfg.rotate_smooth ? 19'(hs_sat) : 19'(target);
      OP_PUBLISH: begin
        out_r.vel_x   <= vx_r;
        out_r.vel_z   <= vz_r;
        out_r.heading <= head_r;
      end
      default: ;
    endcase
  end

  assign out_item = out_r;

endmodule

`default_nettype wire

// ----- tb/boid_steering_combiner_tb.sv -----
// self-checking testbench of the boid steering combiner
`timescale 1ns / 1ps

import bsc_pkg::*;

// holds the combiner state and the queue of expected velocity and heading results
class steer_scoreboard;
  logic [30:0]     regs [8];
  logic signed [63:0] head_q;
  logic signed [63:0] jit_x, jit_z;
  logic [1:0]      dir_x, dir_z;
  out_item_t       pending [$];
  int              errors;

  function void reset_state();
    regs[CFG_COHESION_GAIN]  = 31'd459;
    regs[CFG_ALIGNMENT_GAIN] = 31'd58982;
    regs[CFG_MIN_SPEED]      = 31'd983040;
    regs[CFG_MAX_SPEED]      = 31'd1966080;
    regs[CFG_BOUND_PUSH]     = 31'd655360;
    regs[CFG_HALF_WIDTH_X]   = 31'd13107200;
    regs[CFG_HALF_WIDTH_Z]   = 31'd13107200;
    regs[CFG_ROTATE_SMOOTH]  = 31'd0;
    head_q = 0; jit_x = 0; jit_z = 0;
    dir_x = PUSH_NONE; dir_z = PUSH_NONE;
    errors = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [30:0] val);
    logic [30:0] msk [8];
    msk = '{31'h1FFFF, 31'h1FFFF, 31'hFFFFFF, 31'hFFFFFF, 31'hFFFFFF,
            31'h7FFFFFFF, 31'h7FFFFFFF, 31'h1};
    regs[idx] = val & msk[idx];
  endfunction

  // n / d rounded half away from zero
  function logic signed [63:0] rdiv(logic signed [63:0] n, logic [63:0] d);
    logic [63:0] m;
    m = n < 0 ? -n : n;
    m = (m + d / 2) / d;
    return n < 0 ? -$signed(m) : $signed(m);
  endfunction

  function logic signed [63:0] fshift(logic signed [63:0] v, int s);
    return v >>> s;
  endfunction

  function logic signed [63:0] to_q(logic [63:0] t);
    return $signed(t + (64'd1 << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
  endfunction

  function logic signed [63:0] sat32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function logic [63:0] root(logic [63:0] v);
    logic [63:0] r, b;
    r = 0; b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b); r = (r >> 1) + b;
      end else r = r >> 1;
      b = b >> 2;
    end
    return r;
  endfunction

  function logic signed [63:0] jitter_of(logic [5:0] draw, logic wide);
    logic signed [63:0] m, r;
    m = wide ? 64'sd40 : 64'sd30;
    r = $signed(64'(draw)) % m;
    return rdiv((2 * r - m) * (64'sd1 << FRAC_BITS), 200);
  endfunction

  function logic signed [63:0] push_of(logic [1:0] d);
    if (d == PUSH_PLUS) return $signed({33'd0, regs[CFG_BOUND_PUSH]});
    if (d == PUSH_MINUS) return -$signed({33'd0, regs[CFG_BOUND_PUSH]});
    return 0;
  endfunction

  function logic signed [63:0] heading_of(logic signed [63:0] vx, logic signed [63:0] vz);
    logic [63:0] tab [24];
    logic signed [63:0] pi, x, y, a, nx, ny, t;
    tab = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
            16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
            131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};
    pi = to_q(PI_Q30);
    if (vx == 0) return vz >= 0 ? 0 : pi;
    x = vz; y = vx; a = 0;
    if (x < 0) begin
      a = y >= 0 ? pi : -pi;
      x = -x; y = -y;
    end
    for (int i = 0; i < ANGLE_ITERS; i++) begin
      t = to_q(tab[i]);
      if (y > 0) begin
        nx = x + fshift(y, i); ny = y - fshift(x, i); a = a + t;
      end else begin
        nx = x - fshift(y, i); ny = y + fshift(x, i); a = a - t;
      end
      x = nx; y = ny;
    end
    if (a > pi) a = pi;
    if (a < -pi) a = -pi;
    return a;
  endfunction

  function void note_input(in_item_t it);
    logic signed [63:0] vx, vz, ox, oz, hx, hz, lim, tgt, pi, dt, cg, ag;
    logic [63:0] len;
    out_item_t r;
    cg = $signed(64'(regs[CFG_COHESION_GAIN]));
    ag = $signed(64'(regs[CFG_ALIGNMENT_GAIN]));
    dt = $signed(64'(it.time_step));
    if (it.jitter_event == JIT_NARROW || it.jitter_event == JIT_WIDE) begin
      jit_x = jitter_of(it.jitter_draw_x, it.jitter_event == JIT_WIDE);
      jit_z = jitter_of(it.jitter_draw_z, it.jitter_event == JIT_WIDE);
    end
    ox = 64'(it.offset_x); oz = 64'(it.offset_z);
    hx = $signed(64'(regs[CFG_HALF_WIDTH_X])); hz = $signed(64'(regs[CFG_HALF_WIDTH_Z]));
    if (ox > hx) dir_x = PUSH_MINUS;
    if (ox < -hx) dir_x = PUSH_PLUS;
    if (oz > hz) dir_z = PUSH_MINUS;
    if (oz < -hz) dir_z = PUSH_PLUS;
    vx = 64'(it.sep_x) + rdiv(64'(it.coh_x) * cg, 65536) + rdiv(64'(it.ali_x) * ag, 65536)
         + jit_x + push_of(dir_x);
    vz = 64'(it.sep_z) + rdiv(64'(it.coh_z) * cg, 65536) + rdiv(64'(it.ali_z) * ag, 65536)
         + jit_z + push_of(dir_z);
    vx = sat32(vx); vz = sat32(vz);
    len = root(vx * vx + vz * vz);
    if (dt > 0 && len > 0) begin
      lim = -1;
      if (len > regs[CFG_MAX_SPEED]) lim = $signed(64'(regs[CFG_MAX_SPEED]));
      else if (len < regs[CFG_MIN_SPEED]) lim = $signed(64'(regs[CFG_MIN_SPEED]));
      if (lim >= 0) begin
        vx = rdiv(vx * lim, len);
        vz = rdiv(vz * lim, len);
      end
    end
    tgt = heading_of(vx, vz);
    pi = to_q(PI_Q30);
    if (regs[CFG_ROTATE_SMOOTH][0]) begin
      tgt = head_q + rdiv(2 * dt * (tgt - head_q), 65536);
      if (tgt > pi) tgt = pi;
      if (tgt < -pi) tgt = -pi;
    end
    head_q = tgt;
    r.vel_x = vx[31:0]; r.vel_z = vz[31:0]; r.heading = tgt[18:0];
    pending.push_back(r);
  endfunction

  function void check_result(out_item_t got);
    out_item_t exp_r;
    if (pending.size() == 0) begin
      $error("unexpected result transaction %h", got);
      errors++;
      return;
    end
    exp_r = pending.pop_front();
    if (got.vel_x !== exp_r.vel_x) begin
      $error("vel_x expected %0d actual %0d", exp_r.vel_x, got.vel_x); errors++;
    end
    if (got.vel_z !== exp_r.vel_z) begin
      $error("vel_z expected %0d actual %0d", exp_r.vel_z, got.vel_z); errors++;
    end
    if (got.heading !== exp_r.heading) begin
      $error("heading expected %0d actual %0d", exp_r.heading, got.heading); errors++;
    end
  endfunction
endclass

module boid_steering_combiner_tb;
  localparam int RANDOM_ITEMS = 1130;
  localparam int STALL_LIMIT  = 20000;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [287:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [87:0]  out_tdata;
  logic         cfg_we = 0;
  logic [2:0]   cfg_index = '0;
  logic [30:0]  cfg_wdata = '0;

  steer_scoreboard sb;
  bit   calm;
  int   idle_cycles;
  int   out_stall;

  always #1 clk = ~clk;

  boid_steering_combiner u_top (.*);

  function automatic out_item_t unpack_out(logic [87:0] d);
    out_item_t r;
    r.vel_x   = d[31:0];
    r.vel_z   = d[63:32];
    r.heading = d[82:64];
    return r;
  endfunction

  // result side: lowers ready at random, never while calm, and checks each accepted transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(unpack_out(out_tdata));
      if (calm) begin
        out_tready <= 1'b1;
      end else if (out_stall > 0) begin
        out_tready <= 1'b0;
        out_stall  <= out_stall - 1;
      end else if ($urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        out_stall  <= int'($urandom_range(0, 2));
      end else begin
        out_tready <= 1'b1;
      end
    end else begin
      out_stall <= 0;
    end
  end

  // watchdog on cycles with no transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // valid stays up between back to back items unless a random gap lowers it outside calm mode; drain lowers it
  task automatic send_item(in_item_t it);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, it.jitter_draw_z, it.jitter_draw_x, it.jitter_event, it.time_step,
                  it.offset_z, it.offset_x, it.ali_z, it.ali_x, it.coh_z, it.coh_x,
                  it.sep_z, it.sep_x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(it);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [30:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (140) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_vec();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
      default: return 32'($signed($urandom_range(0, 40 << 16)) - (20 << 16));
    endcase
  endfunction

  function automatic in_item_t rnd_item();
    in_item_t it;
    it.sep_x = rnd_vec(); it.sep_z = rnd_vec();
    it.coh_x = rnd_vec(); it.coh_z = rnd_vec();
    it.ali_x = rnd_vec(); it.ali_z = rnd_vec();
    it.offset_x = $urandom_range(0, 3) == 0 ? $urandom : rnd_vec() * 16;
    it.offset_z = $urandom_range(0, 3) == 0 ? $urandom : rnd_vec() * 16;
    case ($urandom_range(0, 5))
      0: it.time_step = '0;
      1: it.time_step = 17'($urandom);
      default: it.time_step = 17'($urandom_range(1, 65536));
    endcase
    it.jitter_event  = 2'($urandom);
    it.jitter_draw_x = 6'($urandom);
    it.jitter_draw_z = 6'($urandom);
    return it;
  endfunction

  task automatic random_cfg();
    write_reg(CFG_COHESION_GAIN,
              31'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 65536)));
    write_reg(CFG_ALIGNMENT_GAIN, 31'($urandom_range(0, 65536)));
    write_reg(CFG_MIN_SPEED,
              31'($urandom_range(0, 4) == 0 ? $urandom : $urandom_range(0, 3 << 16)));
    write_reg(CFG_MAX_SPEED,
              31'($urandom_range(0, 4) == 0 ? $urandom : $urandom_range(0, 30 << 16)));
    write_reg(CFG_BOUND_PUSH, 31'($urandom));
    write_reg(CFG_HALF_WIDTH_X,
              31'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 400 << 16)));
    write_reg(CFG_HALF_WIDTH_Z,
              31'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 400 << 16)));
    write_reg(CFG_ROTATE_SMOOTH, 31'($urandom));
  endtask

  initial begin
    in_item_t it;
    sb = new();
    sb.reset_state();
    calm = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero vector, extremes, every jitter code, pushes both ways
    it = '0;
    send_item(it);
    it.time_step = 17'd65536; it.sep_z = -32'sd5;
    send_item(it);
    it = '0; it.sep_x = 32'h7FFFFFFF; it.sep_z = 32'h7FFFFFFF; it.coh_x = 32'h7FFFFFFF;
    it.ali_x = 32'h7FFFFFFF; it.time_step = 17'h1FFFF;
    send_item(it);
    it = '0; it.sep_x = 32'h80000000; it.sep_z = 32'h80000000; it.ali_z = 32'h80000000;
    it.time_step = 17'd1;
    send_item(it);
    for (int ev = 0; ev < 4; ev++) begin
      it = '0; it.jitter_event = 2'(ev); it.jitter_draw_x = 6'h3F; it.jitter_draw_z = 6'd0;
      it.time_step = 17'd100; it.offset_x = 32'h7FFFFFFF; it.offset_z = 32'h80000000;
      send_item(it);
      it.jitter_draw_x = 6'(29 + ev); it.jitter_draw_z = 6'd39; it.offset_x = 32'h80000000;
      it.offset_z = 32'h7FFFFFFF; it.sep_z = -32'sd65536;
      send_item(it);
    end
    it = '0; it.sep_x = 32'sd100; it.time_step = '0;
    send_item(it);
    drain();

    // extremes of the registers, smoothing on
    write_reg(CFG_COHESION_GAIN, 31'h1FFFF);
    write_reg(CFG_ALIGNMENT_GAIN, 31'd0);
    write_reg(CFG_MIN_SPEED, 31'hFFFFFF);
    write_reg(CFG_MAX_SPEED, 31'hFFFFFF);
    write_reg(CFG_BOUND_PUSH, 31'hFFFFFF);
    write_reg(CFG_HALF_WIDTH_X, 31'd0);
    write_reg(CFG_HALF_WIDTH_Z, 31'h7FFFFFFF);
    write_reg(CFG_ROTATE_SMOOTH, 31'd1);
    for (int k = 0; k < 6; k++) send_item(rnd_item());
    drain();
    write_reg(CFG_MIN_SPEED, 31'd0);
    write_reg(CFG_MAX_SPEED, 31'd0);
    write_reg(CFG_BOUND_PUSH, 31'd0);
    for (int k = 0; k < 4; k++) send_item(rnd_item());
    drain();

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 120 == 0) begin
        drain();
        random_cfg();
      end
      if (k == RANDOM_ITEMS - 150) calm = 1;
      send_item(rnd_item());
    end
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
